// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cfr_pkg.sv -----
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int COMMAND_LENGTH = 5;
    localparam int CNT_W          = 3;
    localparam int TABLE_ROWS     = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [7:0]  TIME_SYNC_OPCODE = 8'h78;
    localparam logic [7:0]  HEADER_RESET     = 8'h7F;
    localparam logic [7:0]  FOOTER_RESET     = 8'h7E;
    localparam logic [31:0] OFFSET_RESET     = 32'(8 * 3600);

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_FOOT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_BAD_FOOTER = 2'd1,
        ST_CSUM_ERR   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        CLS_UNKNOWN     = 4'd0,
        CLS_CARD_IN     = 4'd1,
        CLS_CARD_OUT    = 4'd2,
        CLS_SLEEP       = 4'd3,
        CLS_BRIGHT      = 4'd4,
        CLS_PLAY        = 4'd5,
        CLS_STOP        = 4'd6,
        CLS_PREV        = 4'd7,
        CLS_NEXT        = 4'd8,
        CLS_PLAY_PAUSE  = 4'd9,
        CLS_QUERY       = 4'd10,
        CLS_TIME_SYNC   = 4'd11,
        CLS_TRACE_START = 4'd12,
        CLS_TRACE_STOP  = 4'd13
    } t_cmd_class;

    typedef logic [COMMAND_LENGTH-1:0][7:0] t_cmd_bytes;

    typedef struct packed {
        t_cmd_class  cmd_class;
        logic [31:0] time_value;
    } t_cls_result;

    // First command byte sits in the top byte of each row.
    localparam logic [39:0] CMD_TABLE [TABLE_ROWS] = '{
        40'h80_01_00_26_01,
        40'h80_01_00_26_00,
        40'h80_1E_01_0A_00,
        40'h80_1E_01_01_00,
        40'hA8_00_00_00_02,
        40'hA8_00_00_00_03,
        40'hA8_00_00_00_04,
        40'hA8_00_00_00_05,
        40'hA8_00_00_00_0C,
        40'h16_A0_00_02_01,
        40'h80_01_03_26_01,
        40'h80_01_04_26_01
    };

    localparam t_cmd_class CMD_CLASS_OF_ROW [TABLE_ROWS] = '{
        CLS_CARD_IN, CLS_CARD_OUT, CLS_SLEEP, CLS_BRIGHT, CLS_PLAY, CLS_STOP,
        CLS_PREV, CLS_NEXT, CLS_PLAY_PAUSE, CLS_QUERY, CLS_TRACE_START,
        CLS_TRACE_STOP
    };

endpackage

// ----- sv/cfr_byte_if.sv -----
`timescale 1ns / 1ps

interface cfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/cfr_result_if.sv -----
`timescale 1ns / 1ps

interface cfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [3:0]  command_class;
    logic [31:0] time_value;

    modport source (
        output valid, output frame_status, output command_class, output time_value,
        input ready
    );
    modport sink (
        input valid, input frame_status, input command_class, input time_value,
        output ready
    );
endinterface

// ----- sv/cfr_classify.sv -----
`timescale 1ns / 1ps

module cfr_classify
    import cfr_pkg::*;
(
    input  t_cmd_bytes  i_cmd,
    input  logic [31:0] i_time_offset,
    output t_cls_result o_cls
);

    logic [39:0]           w_key;
    logic [TABLE_ROWS-1:0] w_hit;
    logic [31:0]           w_stamp;
    logic                  w_sync;

    assign w_key   = {i_cmd[0], i_cmd[1], i_cmd[2], i_cmd[3], i_cmd[4]};
    assign w_stamp = {i_cmd[1], i_cmd[2], i_cmd[3], i_cmd[4]};
    assign w_sync  = (i_cmd[0] == TIME_SYNC_OPCODE);

    always_comb begin
        for (int r = 0; r < TABLE_ROWS; r++) begin
            w_hit[r] = (w_key == CMD_TABLE[r]);
        end
    end

    // Priority: the first ten rows, then time sync, then the trace rows.
    always_comb begin
        o_cls.cmd_class  = CLS_UNKNOWN;
        o_cls.time_value = '0;
        for (int r = TABLE_ROWS - 1; r >= 10; r--) begin
            if (w_hit[r]) begin
                o_cls.cmd_class = CMD_CLASS_OF_ROW[r];
            end
        end
        if (w_sync) begin
            o_cls.cmd_class  = CLS_TIME_SYNC;
            o_cls.time_value = w_stamp + i_time_offset;
        end
        for (int r = 9; r >= 0; r--) begin
            if (w_hit[r]) begin
                o_cls.cmd_class  = CMD_CLASS_OF_ROW[r];
                o_cls.time_value = '0;
            end
        end
    end

endmodule

// ----- sv/command_frame_receiver.sv -----
`timescale 1ns / 1ps
// Frame receiver for a byte stream: outside a frame every byte but the header
// value is dropped; a header opens a frame of five command bytes, a checksum
// byte and a footer byte. The footer byte yields one result item (status,
// command class, time value); no other byte yields one. One byte is taken per
// clock cycle unless stalled; the result item appears in the output register
// in the cycle after its footer byte. The input stalls only while that output
// register holds a result item that has not been taken. Configuration writes
// land on the next clock edge and apply from the next byte on.
module command_frame_receiver
    import cfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cfr_byte_if.sink              i_rx,
    cfr_result_if.source          o_res
);

    `include "assert_macros.svh"

    logic [7:0]       r_header;
    logic [7:0]       r_footer;
    logic [31:0]      r_offset;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_body_count, n_body_count;
    t_cmd_bytes       r_cmd, n_cmd;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_csum, n_csum;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    t_cmd_class       r_class, n_class;
    logic [31:0]      r_time, n_time;

    logic             w_rx_acc;
    logic [7:0]       w_byte;
    t_cls_result      w_cls;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_rx_acc   = i_rx.valid && i_rx.ready;
    assign w_byte     = i_rx.rx_byte;

    cfr_classify u_classify (
        .i_cmd         (r_cmd),
        .i_time_offset (r_offset),
        .o_cls         (w_cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER: r_header <= i_cfg_data[7:0];
                CFG_FOOTER: r_footer <= i_cfg_data[7:0];
                CFG_OFFSET: r_offset <= i_cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_rx_acc) begin
            case (r_phase)
                PH_BODY: begin
                    if (r_body_count == CNT_W'(COMMAND_LENGTH)) begin
                        n_phase = PH_FOOT;
                    end
                end
                PH_FOOT: n_phase = PH_IDLE;
                default: n_phase = (w_byte == r_header) ? PH_BODY : PH_IDLE;
            endcase
        end
    end

    // Frame data and result
    always_comb begin
        n_body_count = r_body_count;
        n_cmd        = r_cmd;
        n_sum        = r_sum;
        n_csum       = r_csum;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_status     = r_status;
        n_class      = r_class;
        n_time       = r_time;
        if (w_rx_acc) begin
            case (r_phase)
                PH_BODY: begin
                    if (r_body_count == CNT_W'(COMMAND_LENGTH)) begin
                        n_csum       = w_byte;
                        n_body_count = '0;
                    end else begin
                        n_cmd[r_body_count] = w_byte;
                        n_sum               = r_sum + w_byte;
                        n_body_count        = r_body_count + CNT_W'(1);
                    end
                end
                PH_FOOT: begin
                    n_out_valid = 1'b1;
                    n_class     = CLS_UNKNOWN;
                    n_time      = '0;
                    if (w_byte != r_footer) begin
                        n_status = ST_BAD_FOOTER;
                    end else if (r_sum != r_csum) begin
                        n_status = ST_CSUM_ERR;
                    end else begin
                        n_status = ST_VALID;
                        n_class  = w_cls.cmd_class;
                        n_time   = w_cls.time_value;
                    end
                end
                default: begin
                    if (w_byte == r_header) begin
                        n_body_count = '0;
                        n_cmd        = '0;
                        n_csum       = '0;
                        n_sum        = w_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_body_count <= '0;
            r_sum        <= '0;
            r_csum       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_body_count <= n_body_count;
            r_sum        <= n_sum;
            r_csum       <= n_csum;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_class  <= n_class;
        r_time   <= n_time;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.frame_status  = r_status;
    assign o_res.command_class = r_class;
    assign o_res.time_value    = r_time;

    `ASSERT_NEXT(a_footer_gives_result, w_rx_acc && r_phase == PH_FOOT, r_out_valid, "footer byte without result item")
    `ASSERT_NOW(a_error_has_no_class, r_out_valid && r_status != ST_VALID, r_class == CLS_UNKNOWN && r_time == '0, "error result carries a class or time")
    `ASSERT_NOW(a_time_only_on_sync, r_out_valid && r_class != CLS_TIME_SYNC, r_time == '0, "time value outside time sync")
    `ASSERT_NOW(a_count_idle_zero, r_phase != PH_BODY, r_body_count == '0, "body count left nonzero outside body")

endmodule

// ----- sim/command_frame_receiver_test.sv -----
`timescale 1ns / 1ps

module command_frame_receiver_test;
    import cfr_pkg::*;

    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_BYTES     = 300;
    localparam int STIM_ROWS       = 27;

    typedef struct packed {
        t_status     status;
        t_cmd_class  cmd_class;
        logic [31:0] time_value;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    rx_byte;
        logic          typed;
        t_frame_result want;
    } t_stim_row;

    localparam t_frame_result NO_RES = '{ST_VALID, CLS_UNKNOWN, 32'd0};

    // Directed bytes under reset configuration; typed rows carry their footer result.
    localparam t_stim_row STIM_TABLE [STIM_ROWS] = '{
        // dropped while idle, footer value included
        '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        // time sync, header value in the body, timestamp wraps with the offset
        '{8'h7F, 1'b0, NO_RES},
        '{8'h78, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h7F, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h73, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        // header value in footer position: bad footer, not a new frame
        '{8'h7F, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h7F, 1'b0, NO_RES},
        '{8'h7F, 1'b1, '{ST_BAD_FOOTER, CLS_UNKNOWN, 32'd0}},
        // all-ones body with a wrong checksum
        '{8'h7F, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h7E, 1'b1, '{ST_CSUM_ERR, CLS_UNKNOWN, 32'd0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfr_byte_if   rx_if ();
    cfr_result_if res_if ();

    command_frame_receiver i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    always #6 clk = ~clk;

    // Receiver state mirror and its configuration copy
    t_phase      rx_phase;
    int          body_seen;
    logic [39:0] cmd_word;
    logic [7:0]  sum_acc;
    logic [7:0]  csum_rcv;
    logic [7:0]  hdr_val;
    logic [7:0]  ftr_val;
    logic [31:0] offset_val;

    t_frame_result awaited_frames[$];
    int            mismatch_count = 0;
    bit            sender_gaps    = 1'b1;
    bit            sink_stalls    = 1'b1;
    bit            sink_hold_req  = 1'b0;

    function automatic t_frame_result classify_command(input logic [39:0] cmd);
        t_frame_result res;
        res = NO_RES;
        for (int r = 0; r < TABLE_ROWS; r++) begin
            if (cmd == CMD_TABLE[r]) begin
                res.cmd_class = CMD_CLASS_OF_ROW[r];
                return res;
            end
        end
        // no table row starts with the time-sync opcode, so the order is free
        if (cmd[39:32] == TIME_SYNC_OPCODE) begin
            res.cmd_class  = CLS_TIME_SYNC;
            res.time_value = cmd[31:0] + offset_val;
        end
        return res;
    endfunction

    function automatic bit advance_receiver(input logic [7:0] b, output t_frame_result res);
        res = NO_RES;
        advance_receiver = 1'b0;
        case (rx_phase)
            PH_BODY: begin
                if (body_seen < COMMAND_LENGTH) begin
                    cmd_word = {cmd_word[31:0], b};
                    sum_acc  = sum_acc + b;
                    body_seen++;
                end else begin
                    csum_rcv  = b;
                    body_seen = 0;
                    rx_phase  = PH_FOOT;
                end
            end
            PH_FOOT: begin
                rx_phase = PH_IDLE;
                advance_receiver = 1'b1;
                if (b != ftr_val)
                    res.status = ST_BAD_FOOTER;
                else if (sum_acc != csum_rcv)
                    res.status = ST_CSUM_ERR;
                else
                    res = classify_command(cmd_word);
            end
            default: begin
                rx_phase = PH_IDLE;
                if (b == hdr_val) begin
                    rx_phase  = PH_BODY;
                    body_seen = 0;
                    cmd_word  = '0;
                    csum_rcv  = 8'd0;
                    sum_acc   = b;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Handshake one item; returns at the edge that accepts it.
    task automatic offer_byte(input logic [7:0] b);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
    endtask

    task automatic feed(input logic [7:0] b);
        t_frame_result res;
        offer_byte(b);
        if (advance_receiver(b, res))
            awaited_frames.push_back(res);
    endtask

    task automatic send_random_frame();
        logic [39:0] cmd;
        logic [7:0]  csum;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            cmd = CMD_TABLE[$urandom_range(0, TABLE_ROWS - 1)];
        end else if (pick < 65) begin
            case ($urandom_range(0, 3))
                0:       cmd = {TIME_SYNC_OPCODE, 32'hFFFF_FFFF};
                1:       cmd = {TIME_SYNC_OPCODE, 32'd0};
                default: cmd = {TIME_SYNC_OPCODE, 32'($urandom())};
            endcase
        end else if (pick < 80) begin
            cmd = {32'($urandom()), 8'($urandom())};
        end else begin
            // near miss: one bit off a known command
            cmd = CMD_TABLE[$urandom_range(0, TABLE_ROWS - 1)];
            pick = $urandom_range(0, 39);
            cmd[pick] = ~cmd[pick];
        end
        if ($urandom_range(0, 9) == 0)
            cmd[8 * $urandom_range(0, 4) +: 8] = hdr_val;
        csum = hdr_val + cmd[39:32] + cmd[31:24] + cmd[23:16] + cmd[15:8] + cmd[7:0];
        if ($urandom_range(0, 6) == 0)
            csum = csum + 8'($urandom_range(1, 255));
        feed(hdr_val);
        for (int k = 4; k >= 0; k--)
            feed(cmd[8 * k +: 8]);
        feed(csum);
        if ($urandom_range(0, 6) == 0)
            feed(8'($urandom()));
        else
            feed(ftr_val);
    endtask

    task automatic run_traffic(input int frame_bytes);
        int sent;
        sent = 0;
        while (sent < frame_bytes) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 9))
                        0:       feed(hdr_val);
                        1:       feed(ftr_val);
                        default: feed(8'($urandom()));
                    endcase
                end
            end
            send_random_frame();
            sent += 8;
        end
        // close a frame that noise left open
        while (rx_phase != PH_IDLE)
            feed(8'($urandom()));
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        wait (awaited_frames.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] hdr, input logic [7:0] ftr,
                                input logic [31:0] offs);
        // upper data bits are junk for the byte-wide registers
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEADER;
        cfg_data  <= {24'($urandom()), hdr};
        @(posedge clk);
        cfg_index <= CFG_FOOTER;
        cfg_data  <= {24'($urandom()), ftr};
        @(posedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= offs;
        @(posedge clk);
        cfg_we     <= 1'b0;
        hdr_val    = hdr;
        ftr_val    = ftr;
        offset_val = offs;
    endtask

    initial begin : stimulus
        t_frame_result res;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_HEADER;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'd0;
        rx_phase   = PH_IDLE;
        body_seen  = 0;
        cmd_word   = '0;
        sum_acc    = 8'd0;
        csum_rcv   = 8'd0;
        hdr_val    = HEADER_RESET;
        ftr_val    = FOOTER_RESET;
        offset_val = OFFSET_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < STIM_ROWS; i++) begin
            offer_byte(STIM_TABLE[i].rx_byte);
            if (advance_receiver(STIM_TABLE[i].rx_byte, res))
                awaited_frames.push_back(STIM_TABLE[i].typed ? STIM_TABLE[i].want : res);
        end
        wait_drained();

        write_config(8'h00, 8'hFF, 32'hFFFF_FFFF);
        // hold the result side while frames keep coming, so the input backs up
        sink_hold_req = 1'b1;
        repeat (4) send_random_frame();
        run_traffic(PHASE_BYTES);
        wait_drained();

        write_config(8'hFF, 8'h00, 32'd0);
        run_traffic(PHASE_BYTES);
        wait_drained();

        write_config(8'h55, 8'h55, 32'($urandom()));
        run_traffic(PHASE_BYTES);
        wait_drained();

        write_config(8'($urandom()), 8'($urandom()), 32'($urandom()));
        run_traffic(PHASE_BYTES);
        wait_drained();

        write_config(HEADER_RESET, FOOTER_RESET, OFFSET_RESET);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_traffic(PHASE_BYTES);
        wait_drained();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : result_sink
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (sink_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_frame_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (awaited_frames.size() == 0) begin
                report_mismatch($sformatf("result item with none expected: %0d %0d %0h",
                    res_if.frame_status, res_if.command_class, res_if.time_value));
            end else begin
                want = awaited_frames.pop_front();
                if (res_if.frame_status !== want.status)
                    report_mismatch($sformatf("frame_status: expected %0d, got %0d",
                        want.status, res_if.frame_status));
                if (res_if.command_class !== want.cmd_class)
                    report_mismatch($sformatf("command_class: expected %0d, got %0d",
                        want.cmd_class, res_if.command_class));
                if (res_if.time_value !== want.time_value)
                    report_mismatch($sformatf("time_value: expected %08h, got %08h",
                        want.time_value, res_if.time_value));
            end
        end
    end

    initial begin : watchdog
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cfr_pkg.sv
sv/cfr_byte_if.sv
sv/cfr_result_if.sv
sv/cfr_classify.sv
sv/command_frame_receiver.sv
sim/command_frame_receiver_test.sv
